@@ rtl/core/priority_ready_queue_macros.svh @@
// assertion helpers for the checker file
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define PRQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("priority ready queue check failed");

// consequence must hold in the cycle after the antecedent
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("priority ready queue check failed");

`endif

@@ rtl/core/prq_pkg.sv @@
`timescale 1ns / 1ps
package prq_pkg;

   localparam int DEPTH      = 16;
   localparam int ID_WIDTH   = 8;
   localparam int PRIO_WIDTH = 8;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int CAP_WIDTH  = 5;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

   // register index, taken from the word address bit
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      CMD_PUSH_TAIL   = 2'd0,
      CMD_PUSH_SORTED = 2'd1,
      CMD_POP_HEAD    = 2'd2,
      CMD_REMOVE_ID   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      cmd_type               cmd;
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
      logic                  write_en;
   } cell_ctl_type;

   // flags and data rippling from cell k to cell k+1
   typedef struct packed {
      logic      pass;  // every earlier cell is held with prio <= request prio
      logic      seen;  // an earlier cell holds the request id
      logic      ge;    // this cell sits at or after the insertion point
      entry_type sel;   // first cell that holds the request id
   } chain_type;

endpackage

@@ rtl/core/prq_if.sv @@
`timescale 1ns / 1ps
interface prq_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      cmd;
   logic [prq_pkg::ID_WIDTH-1:0]    thread_id;
   logic [prq_pkg::PRIO_WIDTH-1:0]  priority_req;

   modport source (output valid, output cmd, output thread_id, output priority_req,
                   input ready);
   modport sink   (input valid, input cmd, input thread_id, input priority_req,
                   output ready);
endinterface

interface prq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic                            out_valid;
   logic [prq_pkg::ID_WIDTH-1:0]    out_id;
   logic [prq_pkg::PRIO_WIDTH-1:0]  out_prio;
   logic [prq_pkg::CNT_WIDTH-1:0]   entry_count;
   logic                            head_valid;
   logic [prq_pkg::ID_WIDTH-1:0]    head_id;

   modport source (output valid, output status, output out_valid, output out_id,
                   output out_prio, output entry_count, output head_valid,
                   output head_id, input ready);
   modport sink   (input valid, input status, input out_valid, input out_id,
                   input out_prio, input entry_count, input head_valid,
                   input head_id, output ready);
endinterface

@@ rtl/core/prq_cell.sv @@
`timescale 1ns / 1ps
module prq_cell (
   input  logic                  clock,
   input  prq_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  prq_pkg::entry_type    left,
   input  prq_pkg::entry_type    right,
   input  prq_pkg::chain_type    chain_in,
   output prq_pkg::chain_type    chain_out,
   output prq_pkg::entry_type    cur,
   output prq_pkg::entry_type    nxt
);

   prq_pkg::entry_type entry_ff;
   prq_pkg::entry_type entry_in;
   prq_pkg::entry_type fresh;
   logic               match;
   logic               prio_le;
   logic               first_hit;

   assign cur        = entry_ff;
   assign fresh.id   = ctl.id;
   assign fresh.prio = ctl.prio;

   assign match     = occ && (entry_ff.id == ctl.id);
   assign prio_le   = occ && (entry_ff.prio <= ctl.prio);
   assign first_hit = match && !chain_in.seen;

   always_comb begin
      chain_out.pass = chain_in.pass && prio_le;
      chain_out.seen = chain_in.seen || match;
      chain_out.sel  = first_hit ? entry_ff : chain_in.sel;
      if (ctl.cmd == prq_pkg::CMD_PUSH_TAIL) begin
         chain_out.ge = !occ;
      end else begin
         chain_out.ge = !(chain_in.pass && prio_le);
      end
   end

   // chain_in.ge from the left neighbor means this cell lies past the insertion point
   always_comb begin
      case (ctl.cmd) inside
         prq_pkg::CMD_PUSH_TAIL, prq_pkg::CMD_PUSH_SORTED: begin
            if (chain_in.ge) begin
               entry_in = left;
            end else if (chain_out.ge) begin
               entry_in = fresh;
            end else begin
               entry_in = entry_ff;
            end
         end
         prq_pkg::CMD_POP_HEAD: begin
            entry_in = right;
         end
         prq_pkg::CMD_REMOVE_ID: begin
            entry_in = (chain_in.seen || match) ? right : entry_ff;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   assign nxt = entry_in;

   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ rtl/core/priority_ready_queue.sv @@
`timescale 1ns / 1ps
// priority ready queue: holds up to 16 thread entries (id, priority) in a row of
// shift cells, head in cell 0. each request is one of push at tail, sorted push
// (placed behind every entry of lower or equal priority), pop head, or remove by
// id, and returns one response with status, the entry taken out, the entry count
// and the head id. a request is accepted every cycle as long as the response
// register is empty or being taken on the same cycle; its response is registered
// and shows in the cycle after acceptance. the cycle time is set by the
// insertion-point and id-match flags that ripple through all cells of the chain.
// pushes of an id already held are refused as duplicates; pushes beyond the
// capacity register (saturated at the depth, 0 refuses all) report full. no
// clearing pass is needed after reset: cells past the entry count are never read.
module priority_ready_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   prq_req_if.sink                              req_chan,
   prq_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [prq_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [prq_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [prq_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int D  = prq_pkg::DEPTH;
   localparam int CW = prq_pkg::CNT_WIDTH;

   // control state
   logic [CW-1:0]                 count_ff, count_in;
   logic [prq_pkg::CAP_WIDTH-1:0] cap_ff;
   logic                          rsp_valid_ff;

   // response payload register
   prq_pkg::status_type           status_ff;
   logic                          out_valid_ff;
   prq_pkg::entry_type            out_entry_ff;
   logic [CW-1:0]                 count_rsp_ff;
   logic                          head_valid_ff;
   logic [prq_pkg::ID_WIDTH-1:0]  head_id_ff;

   // request decode
   logic                          accept;
   logic                          csr_write;
   logic [CW-1:0]                 cap_eff;
   prq_pkg::cmd_type              cmd;
   prq_pkg::status_type           status_in;
   logic                          out_valid_in;
   prq_pkg::entry_type            out_entry_in;
   prq_pkg::cell_ctl_type         ctl;

   // cell row
   logic [D-1:0]                  occ;
   prq_pkg::chain_type            chain [D+1];
   prq_pkg::entry_type            cur   [D];
   prq_pkg::entry_type            nxt   [D];

   // register port: single register, pready tied high
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == prq_pkg::CSR_IDX_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == prq_pkg::CSR_IDX_CAPACITY)
                       ? prq_pkg::CSR_DATA_WIDTH'(cap_ff) : '0;

   // effective capacity saturates at the depth
   assign cap_eff = (CW'(cap_ff) > CW'(D)) ? CW'(D) : CW'(cap_ff);

   // request handshake: held off in reset, response register frees up when taken
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd            = prq_pkg::cmd_type'(req_chan.cmd);

   // head of chain: no earlier cell, nothing seen
   assign chain[0].pass = 1'b1;
   assign chain[0].seen = 1'b0;
   assign chain[0].ge   = 1'b0;
   assign chain[0].sel  = '0;

   genvar k;
   generate
      for (k = 0; k < D; k++) begin : g_cell
         prq_pkg::entry_type left_entry;
         prq_pkg::entry_type right_entry;

         assign occ[k] = (CW'(k) < count_ff);

         if (k == 0) begin : g_first
            assign left_entry = '0;
         end else begin : g_mid_l
            assign left_entry = cur[k-1];
         end

         if (k == D - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_mid_r
            assign right_entry = cur[k+1];
         end

         prq_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occ       (occ[k]),
            .left      (left_entry),
            .right     (right_entry),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .cur       (cur[k]),
            .nxt       (nxt[k])
         );
      end
   endgenerate

   // status and removed entry; last chain link carries the id search result
   always_comb begin
      status_in    = prq_pkg::STATUS_OK;
      out_valid_in = 1'b0;
      out_entry_in = '0;
      count_in     = count_ff;
      unique case (cmd)
         prq_pkg::CMD_PUSH_TAIL, prq_pkg::CMD_PUSH_SORTED: begin
            if (chain[D].seen) begin
               status_in = prq_pkg::STATUS_DUPLICATE;
            end else if (count_ff >= cap_eff) begin
               status_in = prq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         prq_pkg::CMD_POP_HEAD: begin
            if (count_ff == '0) begin
               status_in = prq_pkg::STATUS_NOT_FOUND;
            end else begin
               out_valid_in = 1'b1;
               out_entry_in = cur[0];
               count_in     = count_ff - CW'(1);
            end
         end
         prq_pkg::CMD_REMOVE_ID: begin
            if (!chain[D].seen) begin
               status_in = prq_pkg::STATUS_NOT_FOUND;
            end else begin
               out_valid_in = 1'b1;
               out_entry_in = chain[D].sel;
               count_in     = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = prq_pkg::STATUS_OK;
         end
      endcase
   end

   // cells shift only on a request that changes the queue
   assign ctl.cmd      = cmd;
   assign ctl.id       = req_chan.thread_id;
   assign ctl.prio     = req_chan.priority_req;
   assign ctl.write_en = accept && (status_in == prq_pkg::STATUS_OK);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= prq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_write) begin
            cap_ff <= csr_pwdata[prq_pkg::CAP_WIDTH-1:0];
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, head taken from the cell 0 next value
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         out_valid_ff  <= out_valid_in;
         out_entry_ff  <= out_entry_in;
         count_rsp_ff  <= count_in;
         head_valid_ff <= (count_in != '0);
         head_id_ff    <= (count_in == '0) ? '0
                        : (ctl.write_en ? nxt[0].id : cur[0].id);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.out_valid   = out_valid_ff;
   assign rsp_chan.out_id      = out_entry_ff.id;
   assign rsp_chan.out_prio    = out_entry_ff.prio;
   assign rsp_chan.entry_count = count_rsp_ff;
   assign rsp_chan.head_valid  = head_valid_ff;
   assign rsp_chan.head_id     = head_id_ff;

endmodule

@@ rtl/core/prq_checker.sv @@
`timescale 1ns / 1ps
`include "priority_ready_queue_macros.svh"
module prq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [1:0]                          rsp_status,
   input logic                                rsp_out_valid,
   input logic [prq_pkg::ID_WIDTH-1:0]        rsp_out_id,
   input logic [prq_pkg::CNT_WIDTH-1:0]       rsp_entry_count,
   input logic                                rsp_head_valid,
   input logic [prq_pkg::ID_WIDTH-1:0]        rsp_head_id
);

   // stalled response keeps its payload
   `PRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_id) && $stable(rsp_entry_count) && $stable(rsp_head_id))

   // count never exceeds the cell row
   `PRQ_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= prq_pkg::CNT_WIDTH'(prq_pkg::DEPTH))

   // head flag follows the count
   `PRQ_ASSERT_NOW(a_head_flag, clock, reset, rsp_valid, rsp_head_valid == (rsp_entry_count != '0))

   // an entry comes out only on success
   `PRQ_ASSERT_NOW(a_out_ok, clock, reset, rsp_valid && rsp_out_valid, rsp_status == prq_pkg::STATUS_OK)

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_out_valid   (rsp_chan.out_valid),
   .rsp_out_id      (rsp_chan.out_id),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_head_valid  (rsp_chan.head_valid),
   .rsp_head_id     (rsp_chan.head_id)
);

@@ tb/sv/tb_priority_ready_queue.sv @@
`timescale 1ns / 1ps
module tb_priority_ready_queue;

   localparam int RANDOM_ITEMS = 1400;
   localparam int PHASES       = 8;
   localparam int MAX_REPORTS  = 10;
   localparam logic [prq_pkg::CSR_ADDR_WIDTH-1:0] ADDR_CAPACITY =
      prq_pkg::CSR_ADDR_WIDTH'(0);
   // word index 1 is not a register, writes there must be dropped
   localparam logic [prq_pkg::CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED =
      prq_pkg::CSR_ADDR_WIDTH'(4);

   // one response as seen on the rsp channel
   typedef struct {
      prq_pkg::status_type                 status;
      logic                                out_valid;
      logic [prq_pkg::ID_WIDTH-1:0]        out_id;
      logic [prq_pkg::PRIO_WIDTH-1:0]      out_prio;
      logic [prq_pkg::CNT_WIDTH-1:0]       entry_count;
      logic                                head_valid;
      logic [prq_pkg::ID_WIDTH-1:0]        head_id;
   } rsp_fields_type;

   // mirror of the queue contents plus the responses still owed by the block
   class ready_queue_tracker_type;
      logic [prq_pkg::ID_WIDTH-1:0]    held_id[prq_pkg::DEPTH];
      logic [prq_pkg::PRIO_WIDTH-1:0]  held_prio[prq_pkg::DEPTH];
      int                              held;
      logic [prq_pkg::CAP_WIDTH-1:0]   cap_reg;
      rsp_fields_type                  expected_rsp[$];
      int unsigned                     errors;
      int unsigned                     status_seen[4];

      function new();
         held    = 0;
         cap_reg = prq_pkg::CAP_RESET;
         errors  = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      function void set_capacity(input logic [prq_pkg::CSR_DATA_WIDTH-1:0] value);
         cap_reg = value[prq_pkg::CAP_WIDTH-1:0];
      endfunction

      function int effective_cap();
         return (int'(cap_reg) > prq_pkg::DEPTH) ? prq_pkg::DEPTH : int'(cap_reg);
      endfunction

      function int slot_of(input logic [prq_pkg::ID_WIDTH-1:0] id);
         for (int k = 0; k < held; k++)
            if (held_id[k] == id) return k;
         return -1;
      endfunction

      // apply one accepted request to the mirror and queue its response
      function void note_request(input prq_pkg::cmd_type cmd,
                                 input logic [prq_pkg::ID_WIDTH-1:0] id,
                                 input logic [prq_pkg::PRIO_WIDTH-1:0] prio);
         rsp_fields_type r;
         int pos;
         int hit;
         int k;
         r.status    = prq_pkg::STATUS_OK;
         r.out_valid = 1'b0;
         r.out_id    = '0;
         r.out_prio  = '0;
         if (cmd == prq_pkg::CMD_PUSH_TAIL || cmd == prq_pkg::CMD_PUSH_SORTED) begin
            if (slot_of(id) >= 0) begin
               r.status = prq_pkg::STATUS_DUPLICATE;
            end else if (held >= effective_cap()) begin
               r.status = prq_pkg::STATUS_FULL;
            end else begin
               pos = held;
               if (cmd == prq_pkg::CMD_PUSH_SORTED) begin
                  pos = 0;
                  while (pos < held && held_prio[pos] <= prio) pos++;
               end
               for (k = held; k > pos; k--) begin
                  held_id[k]   = held_id[k-1];
                  held_prio[k] = held_prio[k-1];
               end
               held_id[pos]   = id;
               held_prio[pos] = prio;
               held++;
            end
         end else begin
            if (cmd == prq_pkg::CMD_POP_HEAD) hit = (held > 0) ? 0 : -1;
            else hit = slot_of(id);
            if (hit < 0) begin
               r.status = prq_pkg::STATUS_NOT_FOUND;
            end else begin
               r.out_valid = 1'b1;
               r.out_id    = held_id[hit];
               r.out_prio  = held_prio[hit];
               for (k = hit; k + 1 < held; k++) begin
                  held_id[k]   = held_id[k+1];
                  held_prio[k] = held_prio[k+1];
               end
               held--;
            end
         end
         r.entry_count = prq_pkg::CNT_WIDTH'(held);
         r.head_valid  = (held > 0);
         r.head_id     = (held > 0) ? held_id[0] : '0;
         status_seen[r.status]++;
         expected_rsp.push_back(r);
      endfunction

      function void check_response(input rsp_fields_type got);
         rsp_fields_type exp;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("[%0t] response with nothing outstanding: status %0d count %0d",
                        $realtime, got.status, got.entry_count);
            return;
         end
         exp = expected_rsp.pop_front();
         if (got.status !== exp.status || got.out_valid !== exp.out_valid ||
             got.out_id !== exp.out_id || got.out_prio !== exp.out_prio ||
             got.entry_count !== exp.entry_count || got.head_valid !== exp.head_valid ||
             got.head_id !== exp.head_id) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("[%0t] mismatch exp: st %0d ov %0d id %0d pr %0d cnt %0d hv %0d hid %0d",
                        $realtime, exp.status, exp.out_valid, exp.out_id, exp.out_prio,
                        exp.entry_count, exp.head_valid, exp.head_id);
               $display("[%0t]          got: st %0d ov %0d id %0d pr %0d cnt %0d hv %0d hid %0d",
                        $realtime, got.status, got.out_valid, got.out_id, got.out_prio,
                        got.entry_count, got.head_valid, got.head_id);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   prq_req_if req_if ();
   prq_rsp_if rsp_if ();

   logic                                  csr_psel;
   logic                                  csr_penable;
   logic                                  csr_pwrite;
   logic [prq_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr;
   logic [prq_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata;
   logic [prq_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata;
   logic                                  csr_pready;

   ready_queue_tracker_type tracker;

   // percentages for the current idling phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned cap_settings = 0;

   priority_ready_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one request, idling first at the sender's rate, and note it once taken
   task automatic send_request(input prq_pkg::cmd_type cmd,
                               input logic [prq_pkg::ID_WIDTH-1:0] id,
                               input logic [prq_pkg::PRIO_WIDTH-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= cmd;
      req_if.thread_id    <= id;
      req_if.priority_req <= prio;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_request(cmd, id, prio);
      requests_sent++;
   endtask

   // stop sending and wait for every owed response, then let the pipe settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic write_csr(input logic [prq_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [prq_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_CAPACITY) begin
         tracker.set_capacity(data);
         cap_settings++;
      end
   endtask

   // random request, biased so the queue fills and empties repeatedly
   task automatic send_random();
      int unsigned roll;
      int unsigned push_pct;
      prq_pkg::cmd_type cmd;
      logic [prq_pkg::ID_WIDTH-1:0] id;
      logic [prq_pkg::PRIO_WIDTH-1:0] prio;
      // push harder while the queue is below half of its capacity
      push_pct = (tracker.held * 2 < tracker.effective_cap()) ? 65 : 40;
      roll = $urandom_range(99);
      if (roll < push_pct)
         cmd = ($urandom_range(1) == 1) ? prq_pkg::CMD_PUSH_SORTED : prq_pkg::CMD_PUSH_TAIL;
      else if (roll < push_pct + (100 - push_pct) / 2)
         cmd = prq_pkg::CMD_POP_HEAD;
      else
         cmd = prq_pkg::CMD_REMOVE_ID;
      // removes mostly target a held entry; a small id pool makes duplicates common
      if (cmd == prq_pkg::CMD_REMOVE_ID && tracker.held > 0 && $urandom_range(99) < 70)
         id = tracker.held_id[$urandom_range(tracker.held - 1)];
      else if ($urandom_range(99) < 80)
         id = prq_pkg::ID_WIDTH'($urandom_range(23));
      else
         id = prq_pkg::ID_WIDTH'($urandom_range(255));
      // narrow priorities give lots of ties for the sorted push
      roll = $urandom_range(99);
      if (roll < 60)
         prio = prq_pkg::PRIO_WIDTH'($urandom_range(7));
      else if (roll < 75)
         prio = ($urandom_range(1) == 1) ? '1 : '0;
      else
         prio = prq_pkg::PRIO_WIDTH'($urandom_range(255));
      send_request(cmd, id, prio);
   endtask

   // receiver: ready toggles at the phase's stall rate
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response monitor, sampled at the edge where the handshake completes
   always @(posedge clock) begin : rsp_monitor
      rsp_fields_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status      = prq_pkg::status_type'(rsp_if.status);
         got.out_valid   = rsp_if.out_valid;
         got.out_id      = rsp_if.out_id;
         got.out_prio    = rsp_if.out_prio;
         got.entry_count = rsp_if.entry_count;
         got.head_valid  = rsp_if.head_valid;
         got.head_id     = rsp_if.head_id;
         tracker.check_response(got);
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [prq_pkg::CSR_DATA_WIDTH-1:0] cap_word;
      int unsigned per_phase;
      tracker = new();
      req_if.valid        <= 1'b0;
      req_if.cmd          <= prq_pkg::CMD_PUSH_TAIL;
      req_if.thread_id    <= '0;
      req_if.priority_req <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue misses on pop and remove
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      send_request(prq_pkg::CMD_REMOVE_ID,   8'hff, 8'hff);
      // extreme ids and priorities, sorted push ahead of the tail entry
      send_request(prq_pkg::CMD_PUSH_TAIL,   8'h00, 8'hff);
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'hff, 8'h00);
      // ties stay first-come first-served
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'h5a, 8'h80);
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'ha5, 8'h80);
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'h33, 8'hff);
      // duplicate id is refused
      send_request(prq_pkg::CMD_PUSH_TAIL,   8'h5a, 8'h01);
      // remove from the middle, then an absent id
      send_request(prq_pkg::CMD_REMOVE_ID,   8'ha5, 8'h00);
      send_request(prq_pkg::CMD_REMOVE_ID,   8'h77, 8'h00);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);

      // small capacity: full refusal, and duplicate reported ahead of full
      wait_drained();
      write_csr(ADDR_CAPACITY, 32'd2);
      send_request(prq_pkg::CMD_PUSH_TAIL,   8'h10, 8'h40);
      send_request(prq_pkg::CMD_PUSH_TAIL,   8'h33, 8'h40);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'h10, 8'h00);

      // zero capacity refuses every push
      wait_drained();
      write_csr(ADDR_CAPACITY, 32'd0);
      send_request(prq_pkg::CMD_PUSH_SORTED, 8'h44, 8'h20);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      send_request(prq_pkg::CMD_POP_HEAD,    8'h00, 8'h00);
      wait_drained();

      // random phases: capacity and idling change between them
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: cap_word = 32'd16;
            1: cap_word = 32'd31;            // saturates at the depth
            2: cap_word = 32'd1;
            3: cap_word = 32'd17;
            4: cap_word = 32'd0;
            5: cap_word = 32'd5;
            6: cap_word = 32'd9;
            default: begin
               // junk in the unused upper bits
               cap_word = $urandom;
               cap_word[prq_pkg::CAP_WIDTH-1:0] =
                  prq_pkg::CAP_WIDTH'($urandom_range(8, 31));
            end
         endcase
         write_csr(ADDR_CAPACITY, cap_word);
         // a write off the register map must leave capacity alone
         if (p == 2) write_csr(ADDR_UNMAPPED, 32'd31);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         for (int i = 0; i < per_phase; i++) begin
            send_random();
            // mid-phase pause until the block has answered everything
            if (i == per_phase / 2) wait_drained();
         end
         wait_drained();
      end

      repeat (5) @(posedge clock);
      $display("run: %0d requests across %0d capacity settings and four idling patterns",
               requests_sent, cap_settings);
      $display("responses by status: ok %0d, full %0d, not found %0d, duplicate %0d",
               tracker.status_seen[prq_pkg::STATUS_OK],
               tracker.status_seen[prq_pkg::STATUS_FULL],
               tracker.status_seen[prq_pkg::STATUS_NOT_FOUND],
               tracker.status_seen[prq_pkg::STATUS_DUPLICATE]);
      if (tracker.errors == 0 && tracker.expected_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
